// ===== src/art_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// art_pkg: shared constants and a saturating add of the announce refresh table
// Result codes, register indexes and default values.
// ----------------------------------------------------------------------------
package art_pkg;
    localparam int unsigned CAPACITY_DEF = 16;
    localparam logic [15:0] ANNOUNCE_INTERVAL_RST = 16'd1200;
    localparam logic [15:0] CHECK_PERIOD_RST = 16'd60;
    localparam logic [31:0] FOREVER = 32'hFFFF_FFFF;

    localparam logic [2:0] KIND_ADDED     = 3'd0;
    localparam logic [2:0] KIND_REFRESHED = 3'd1;
    localparam logic [2:0] KIND_REJECTED  = 3'd2;
    localparam logic [2:0] KIND_ANNOUNCE  = 3'd3;
    localparam logic [2:0] KIND_TICK_DONE = 3'd4;

    localparam logic REG_INTERVAL = 1'b0;
    localparam logic REG_PERIOD   = 1'b1;

    localparam int unsigned SLOT_W = 64 + 64 + 32 + 16 + 32 + 32;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[32] ? FOREVER : s[31:0];
    endfunction
endpackage

// ===== src/art_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// art_ram: generic simple dual-port synchronous RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module art_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/announce_refresh_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// announce_refresh_table: table of announced keys with refresh and expiry
// Adds, refreshes, expires and announces entries held in slot memory.
// ----------------------------------------------------------------------------
// Entries live in a slot RAM (key, port, refresh, expiry) and an order RAM
// holding slot numbers newest first. Every pass walks the order list with
// an order read, a slot read and an evaluate step per entry. An add that
// inserts runs the scan, then a shift of the order list, then the head
// write and the result; a key hit ends the scan early. A tick walks the list
// once for each pass that is due (expire, then announce) and then gives its
// result; removing an expired entry moves each entry behind it up one place.
// A result beat that the sink holds off stalls the walk at the next beat.
// The result register is separate from the walk, so a finished beat may
// wait while the next item is taken. Slot contents are undefined until
// written.
module announce_refresh_table
    import art_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic         i_command,
    input  logic [63:0]  i_key_upper,
    input  logic [63:0]  i_key_middle,
    input  logic [31:0]  i_key_lower,
    input  logic [15:0]  i_port,
    input  logic [31:0]  i_lifetime,
    input  logic [31:0]  i_now_sec,
    input  logic         i_nodes_available,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [2:0]   o_result_kind,
    output logic [63:0]  o_out_key_upper,
    output logic [63:0]  o_out_key_middle,
    output logic [31:0]  o_out_key_lower,
    output logic [15:0]  o_out_port,
    output logic         o_last,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned RD = (CAPACITY > 1) ? CAPACITY : 2;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_RADDR  = 11'b000_0000_0010,
        S_SADDR  = 11'b000_0000_0100,
        S_EVAL   = 11'b000_0000_1000,
        S_FREE   = 11'b000_0001_0000,
        S_INS    = 11'b000_0010_0000,
        S_DEL    = 11'b000_0100_0000,
        S_ANN    = 11'b000_1000_0000,
        S_DONE   = 11'b001_0000_0000,
        S_OUT    = 11'b010_0000_0000,
        S_DELR   = 11'b100_0000_0000
    } t_state;

    typedef struct packed {
        logic [63:0] ku;
        logic [63:0] km;
        logic [31:0] kl;
        logic [15:0] port;
        logic [31:0] refresh;
        logic [31:0] expiry;
    } t_slot;

    t_state r_state, n_state;
    logic [15:0] r_interval, r_period;
    logic [31:0] r_expire_due, r_announce_due;
    logic [CW-1:0] r_count;
    logic [CAPACITY-1:0] r_used;
    logic [CW-1:0] r_idx;
    logic [AW-1:0] r_slot;
    logic r_announce;

    // captured item
    logic r_cmd, r_nodes;
    logic [63:0] r_ku, r_km;
    logic [31:0] r_kl, r_life, r_now;
    logic [15:0] r_port;

    // output register
    logic r_ovalid;
    logic [2:0] r_okind;
    logic [63:0] r_oku, r_okm;
    logic [31:0] r_okl;
    logic [15:0] r_oport;
    logic r_olast;
    logic [2:0] r_res_kind;
    logic [15:0] r_res_port;

    // memories
    logic slot_we, ord_we;
    logic [AW-1:0] slot_waddr, slot_raddr, ord_waddr, ord_raddr;
    t_slot slot_wdata, slot_rdata;
    logic [AW-1:0] ord_wdata, ord_rdata;

    art_ram #(.WIDTH(SLOT_W), .DEPTH(RD)) u_slot (
        .i_clk(i_clk), .i_we(slot_we), .i_waddr(slot_waddr), .i_wdata(slot_wdata),
        .i_raddr(slot_raddr), .o_rdata(slot_rdata)
    );
    art_ram #(.WIDTH(AW), .DEPTH(RD)) u_order (
        .i_clk(i_clk), .i_we(ord_we), .i_waddr(ord_waddr), .i_wdata(ord_wdata),
        .i_raddr(ord_raddr), .o_rdata(ord_rdata)
    );

    logic [31:0] prev_sec;
    logic key_hit, free_found;
    logic [AW-1:0] free_slot;
    logic out_free;
    logic out_load;

    assign prev_sec = (r_now == 32'd0) ? 32'd0 : r_now - 32'd1;
    assign key_hit  = (slot_rdata.ku == r_ku) && (slot_rdata.km == r_km) &&
                      (slot_rdata.kl == r_kl);
    assign out_free = !r_ovalid || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_PERIOD) ? {16'd0, r_period} : {16'd0, r_interval};

    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (!r_used[k]) begin
                free_found = 1'b1;
                free_slot  = AW'(k);
            end
        end
    end

    // memory control
    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = r_slot;
        slot_wdata = slot_rdata;
        slot_raddr = ord_rdata;
        ord_we     = 1'b0;
        ord_waddr  = r_idx[AW-1:0];
        ord_wdata  = ord_rdata;
        ord_raddr  = r_idx[AW-1:0];
        out_load   = 1'b0;
        n_state    = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_RADDR;
            S_RADDR: begin
                if (r_idx < r_count) begin
                    n_state = S_SADDR;
                end else if (!r_cmd) begin
                    n_state = S_FREE;
                end else if (!r_announce && r_announce_due <= r_now && r_nodes) begin
                    // expire pass ended, restart the walk for announcements
                    n_state = S_RADDR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SADDR: n_state = S_EVAL;
            S_EVAL: begin
                slot_raddr = r_slot;
                n_state = S_RADDR;
                if (!r_cmd) begin
                    if (key_hit) begin
                        slot_we = 1'b1;
                        slot_wdata.refresh = prev_sec;
                        if (r_life > r_now) slot_wdata.expiry = r_life;
                        n_state = S_OUT;
                    end
                end else if (!r_announce) begin
                    if (slot_rdata.expiry != FOREVER && slot_rdata.expiry < r_now) begin
                        n_state = S_DELR;
                    end
                end else if (slot_rdata.refresh < r_now) begin
                    if (out_free) begin
                        slot_we = 1'b1;
                        slot_wdata.refresh = sat_add(r_now, r_interval);
                        out_load = 1'b1;
                    end else begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_FREE: begin
                if (!free_found || r_count >= CAP_C) begin
                    n_state = S_OUT;
                end else begin
                    slot_we    = 1'b1;
                    slot_waddr = free_slot;
                    slot_wdata = '{ku: r_ku, km: r_km, kl: r_kl, port: r_port,
                                   refresh: prev_sec, expiry: r_life};
                    n_state    = S_INS;
                end
            end
            S_INS: begin
                // shift down from the tail, reading index r_idx-1
                ord_raddr = AW'(r_idx - CW'(1));
                if (r_idx == '0) begin
                    ord_we    = 1'b1;
                    ord_waddr = '0;
                    ord_wdata = r_slot;
                    n_state   = S_OUT;
                end else begin
                    n_state = S_DEL;
                end
            end
            S_DEL: begin
                if (!r_cmd) begin
                    ord_we    = 1'b1;
                    ord_waddr = AW'(r_idx + CW'(1));
                    ord_raddr = AW'(r_idx - CW'(2));
                    n_state   = S_INS;
                end else begin
                    // removal: move entry r_idx+1 up to r_idx
                    ord_raddr = AW'(r_idx + CW'(2));
                    if (r_idx + CW'(1) >= r_count) begin
                        n_state = S_RADDR;
                    end else begin
                        ord_we    = 1'b1;
                        ord_waddr = r_idx[AW-1:0];
                        n_state   = S_DEL;
                    end
                end
            end
            S_DELR: begin
                ord_raddr = AW'(r_idx + CW'(1));
                n_state = S_DEL;
            end
            S_DONE: if (out_free) begin
                out_load = 1'b1;
                n_state  = S_IDLE;
            end
            S_OUT: if (out_free) begin
                out_load = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_interval     <= ANNOUNCE_INTERVAL_RST;
            r_period       <= CHECK_PERIOD_RST;
            r_expire_due   <= '0;
            r_announce_due <= '0;
            r_count        <= '0;
            r_used         <= '0;
            r_ovalid       <= 1'b0;
            r_idx          <= '0;
            r_announce     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite) begin
                if (paddr[2] == REG_INTERVAL) r_interval <= pwdata[15:0];
                if (paddr[2] == REG_PERIOD)   r_period   <= pwdata[15:0];
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_announce <= 1'b0;
                    // skip the expire pass when it is not due
                    r_idx <= (i_command && !(r_expire_due <= i_now_sec)) ? r_count : '0;
                    if (i_command && r_expire_due <= i_now_sec) begin
                        r_expire_due <= sat_add(i_now_sec, r_period);
                    end
                end
                S_RADDR: begin
                    if (r_idx >= r_count && r_cmd && !r_announce) begin
                        // expire pass ended, start announce pass if due
                        if (r_announce_due <= r_now && r_nodes) begin
                            r_announce <= 1'b1;
                            r_idx      <= '0;
                        end
                    end
                end
                S_SADDR: r_slot <= ord_rdata;
                S_EVAL: begin
                    if (!r_cmd) begin
                        if (key_hit) begin
                            r_announce_due <= '0;
                            r_res_kind     <= KIND_REFRESHED;
                            r_res_port     <= slot_rdata.port;
                        end else begin
                            r_idx <= r_idx + CW'(1);
                        end
                    end else if (!r_announce) begin
                        if (slot_rdata.expiry != FOREVER && slot_rdata.expiry < r_now) begin
                            r_used[r_slot] <= 1'b0;
                        end else begin
                            r_idx <= r_idx + CW'(1);
                        end
                    end else if (slot_rdata.refresh < r_now) begin
                        if (out_free) begin
                            r_okind  <= KIND_ANNOUNCE;
                            r_oku    <= slot_rdata.ku;
                            r_okm    <= slot_rdata.km;
                            r_okl    <= slot_rdata.kl;
                            r_oport  <= slot_rdata.port;
                            r_olast  <= 1'b0;
                            r_idx    <= r_idx + CW'(1);
                        end
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_FREE: begin
                    r_res_port <= r_port;
                    if (!free_found || r_count >= CAP_C) begin
                        r_res_kind <= KIND_REJECTED;
                    end else begin
                        r_res_kind        <= KIND_ADDED;
                        r_used[free_slot] <= 1'b1;
                        r_slot            <= free_slot;
                        r_idx             <= r_count;
                        r_count           <= r_count + CW'(1);
                        r_announce_due    <= '0;
                    end
                end
                S_INS: if (r_idx != '0) r_idx <= r_idx - CW'(1);
                S_DEL: begin
                    if (r_cmd) begin
                        if (r_idx + CW'(1) >= r_count) begin
                            r_count <= r_count - CW'(1);
                            r_idx   <= r_count;
                        end else begin
                            r_idx <= r_idx + CW'(1);
                        end
                    end
                end
                S_DONE: if (out_free) begin
                    if (r_announce) r_announce_due <= sat_add(r_now, r_period);
                    r_okind  <= KIND_TICK_DONE;
                    r_oku    <= '0;
                    r_okm    <= '0;
                    r_okl    <= '0;
                    r_oport  <= '0;
                    r_olast  <= 1'b1;
                end
                S_OUT: if (out_free) begin
                    r_okind <= r_res_kind;
                    r_oku   <= r_ku;
                    r_okm   <= r_km;
                    r_okl   <= r_kl;
                    r_oport <= r_res_port;
                    r_olast <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_cmd   <= i_command;
            r_ku    <= i_key_upper;
            r_km    <= i_key_middle;
            r_kl    <= i_key_lower;
            r_port  <= i_port;
            r_life  <= i_lifetime;
            r_now   <= i_now_sec;
            r_nodes <= i_nodes_available;
        end
    end

    assign o_valid          = r_ovalid;
    assign o_result_kind    = r_okind;
    assign o_out_key_upper  = r_oku;
    assign o_out_key_middle = r_okm;
    assign o_out_key_lower  = r_okl;
    assign o_out_port       = r_oport;
    assign o_last           = r_olast;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C) else $error("entry count beyond capacity");
    a_count_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (CW'($countones(r_used)) == r_count))
        else $error("used bits disagree with entry count");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready) else $error("item accepted while busy");
endmodule
